>>> hw/rtl/sbus_frame_decoder_core_macros.svh
// Assertion macros shared by the SBUS frame decoder RTL
`ifndef SBUS_FRAME_DECODER_CORE_MACROS_SVH
`define SBUS_FRAME_DECODER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFD_ASSERT_IMP(lbl, ante, cons, msg)
`define SFD_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/sfd_pkg.sv
// Types, constants and helpers for the SBUS frame decoder
package sfd_pkg;

  localparam int FRAME_BYTES     = 25;
  localparam int ANALOG_CHANNELS = 16;
  localparam int CH_BITS         = 11;

  localparam logic [7:0]  SYNC_BYTE       = 8'h0F;
  localparam logic [4:0]  FLAG_ADDR       = 5'd23;
  localparam logic [4:0]  FIRST_DATA_ADDR = 5'd1;
  localparam logic [4:0]  FRAME_LEN       = 5'(FRAME_BYTES);
  localparam logic [4:0]  LAST_POS        = 5'(FRAME_BYTES - 1);
  localparam logic [4:0]  LAST_ANALOG_IDX = 5'(ANALOG_CHANNELS - 1);
  localparam logic [4:0]  LAST_IDX        = 5'(ANALOG_CHANNELS + 1);
  localparam logic [3:0]  LAST_CH_BIT     = 4'(CH_BITS - 1);
  localparam logic [10:0] DIGITAL_HIGH    = 11'd1800;
  localparam logic [10:0] DIGITAL_LOW     = 11'd1200;
  localparam logic [11:0] ADJUST_OFFSET   = 12'd875;
  localparam int          FS_BIT          = 3;

  typedef logic [4:0]  addr_t;
  typedef logic [4:0]  idx_t;
  typedef logic [10:0] val_t;
  typedef logic [11:0] adj_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG_RD,
    ST_FLAG_CAP,
    ST_FETCH,
    ST_FILL,
    ST_SHIFT,
    ST_EMIT
  } unpack_state_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic  start;
    addr_t pos;
  } store_stat_t;

  typedef struct packed {
    logic valid;
    idx_t index;
    val_t value;
    logic fail_safe;
    logic last;
  } result_t;

  // v*10/16 + 875, as (8v + 2v) >> 4
  function automatic adj_t adjust(input val_t v);
    logic [14:0] prod;
    prod = ({4'b0, v} << 3) + ({4'b0, v} << 1);
    return {1'b0, prod[14:4]} + ADJUST_OFFSET;
  endfunction

endpackage

>>> hw/rtl/sfd_frame_store.sv
// Frame byte store: byte position tracking and the 25-byte frame memory
module sfd_frame_store (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_accept,
  input  logic [7:0]           wr_byte,
  input  sfd_pkg::rd_req_t     rd,
  output logic [7:0]           rd_data,
  output sfd_pkg::store_stat_t stat
);

  logic [7:0]     mem [sfd_pkg::FRAME_BYTES];
  sfd_pkg::addr_t pos;
  sfd_pkg::addr_t pos_eff;
  logic           start;

  // sync byte restarts the frame
  assign pos_eff = (wr_byte == sfd_pkg::SYNC_BYTE) ? '0 : pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      start <= 1'b0;
    end else begin
      start <= 1'b0;
      if (wr_accept && (pos_eff < sfd_pkg::FRAME_LEN)) begin
        pos   <= pos_eff + 5'd1;
        start <= (pos_eff == sfd_pkg::LAST_POS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_accept && (pos_eff < sfd_pkg::FRAME_LEN)) begin
      mem[pos_eff] <= wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

  assign stat.start = start;
  assign stat.pos   = pos;

endmodule

>>> hw/rtl/sfd_unpack.sv
// Bit-serial channel unpacker: walks the frame bits LSB first into 11-bit channels
module sfd_unpack (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [7:0]       rd_data,
  output sfd_pkg::rd_req_t rd,
  output sfd_pkg::result_t res,
  input  logic             res_ready,
  output logic             busy
);

  sfd_pkg::unpack_state_t state, state_next;
  sfd_pkg::val_t          ch_sr, ch_sr_next;
  logic [7:0]             byte_sr, byte_sr_next;
  logic [2:0]             bit_cnt, bit_cnt_next;
  logic [3:0]             ch_bit, ch_bit_next;
  sfd_pkg::idx_t          ch_idx, ch_idx_next;
  sfd_pkg::addr_t         byte_addr, byte_addr_next;
  logic                   need_fetch, need_fetch_next;
  logic                   dig0, dig0_next;
  logic                   dig1, dig1_next;
  logic                   fs, fs_next;
  logic                   dig_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    ch_sr      <= ch_sr_next;
    byte_sr    <= byte_sr_next;
    bit_cnt    <= bit_cnt_next;
    ch_bit     <= ch_bit_next;
    ch_idx     <= ch_idx_next;
    byte_addr  <= byte_addr_next;
    need_fetch <= need_fetch_next;
    dig0       <= dig0_next;
    dig1       <= dig1_next;
    fs         <= fs_next;
  end

  // flag bit for the digital channel that follows the current one
  assign dig_bit = (ch_idx == sfd_pkg::LAST_ANALOG_IDX) ? dig0 : dig1;

  always_comb begin
    state_next      = state;
    ch_sr_next      = ch_sr;
    byte_sr_next    = byte_sr;
    bit_cnt_next    = bit_cnt;
    ch_bit_next     = ch_bit;
    ch_idx_next     = ch_idx;
    byte_addr_next  = byte_addr;
    need_fetch_next = need_fetch;
    dig0_next       = dig0;
    dig1_next       = dig1;
    fs_next         = fs;
    rd.en           = 1'b0;
    rd.addr         = byte_addr;
    unique case (state)
      sfd_pkg::ST_IDLE: begin
        if (start) begin
          state_next = sfd_pkg::ST_FLAG_RD;
        end
      end
      sfd_pkg::ST_FLAG_RD: begin
        rd.en      = 1'b1;
        rd.addr    = sfd_pkg::FLAG_ADDR;
        state_next = sfd_pkg::ST_FLAG_CAP;
      end
      sfd_pkg::ST_FLAG_CAP: begin
        dig0_next      = rd_data[0];
        dig1_next      = rd_data[1];
        fs_next        = rd_data[sfd_pkg::FS_BIT];
        byte_addr_next = sfd_pkg::FIRST_DATA_ADDR;
        ch_idx_next    = '0;
        ch_bit_next    = '0;
        state_next     = sfd_pkg::ST_FETCH;
      end
      sfd_pkg::ST_FETCH: begin
        rd.en          = 1'b1;
        byte_addr_next = byte_addr + 5'd1;
        state_next     = sfd_pkg::ST_FILL;
      end
      sfd_pkg::ST_FILL: begin
        byte_sr_next = rd_data;
        bit_cnt_next = '0;
        state_next   = sfd_pkg::ST_SHIFT;
      end
      sfd_pkg::ST_SHIFT: begin
        ch_sr_next   = {byte_sr[0], ch_sr[10:1]};
        byte_sr_next = {1'b0, byte_sr[7:1]};
        bit_cnt_next = bit_cnt + 3'd1;
        if (ch_bit == sfd_pkg::LAST_CH_BIT) begin
          ch_bit_next     = '0;
          need_fetch_next = (bit_cnt == 3'd7);
          state_next      = sfd_pkg::ST_EMIT;
        end else begin
          ch_bit_next = ch_bit + 4'd1;
          if (bit_cnt == 3'd7) begin
            state_next = sfd_pkg::ST_FETCH;
          end
        end
      end
      sfd_pkg::ST_EMIT: begin
        if (res_ready) begin
          if (ch_idx == sfd_pkg::LAST_IDX) begin
            state_next = sfd_pkg::ST_IDLE;
          end else begin
            ch_idx_next = ch_idx + 5'd1;
            if (ch_idx >= sfd_pkg::LAST_ANALOG_IDX) begin
              // digital channels need no bits from the frame
              ch_sr_next = dig_bit ? sfd_pkg::DIGITAL_HIGH : sfd_pkg::DIGITAL_LOW;
            end else if (need_fetch) begin
              state_next = sfd_pkg::ST_FETCH;
            end else begin
              state_next = sfd_pkg::ST_SHIFT;
            end
          end
        end
      end
      default: begin
        state_next = sfd_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.valid     = (state == sfd_pkg::ST_EMIT);
  assign res.index     = ch_idx;
  assign res.value     = ch_sr;
  assign res.fail_safe = fs;
  assign res.last      = (ch_idx == sfd_pkg::LAST_IDX);
  assign busy          = (state != sfd_pkg::ST_IDLE);

endmodule

>>> hw/rtl/sbus_frame_decoder_core.sv
// SBUS frame decoder top level: byte store, serial unpacker and output register
//
// channel  dir  tdata fields (lsb first)                        sideband
// s_axis   in   rx_byte[7:0]                                    -
// m_axis   out  channel_index[4:0] channel_value[15:5]          tuser = fail_safe
//               adjusted_value[27:16] zero[31:28]               tlast = last_of_frame
//
// A byte that does not complete a frame leaves s_tready high.
// The frame-ending byte holds input off through the decode: the start, the flag byte
// read, a fetch of each data byte from the frame memory, a shift of each channel bit
// through the serial unpacker, and the emission of each result.
// Input is held off while a frame decodes; m_tready low holds the unpacker.
// rst is synchronous; the frame memory is not cleared.
`include "sbus_frame_decoder_core_macros.svh"

module sbus_frame_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte[7:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // channel_index, channel_value, adjusted_value
  output logic        m_tuser,   // fail_safe
  output logic        m_tlast
);

  sfd_pkg::rd_req_t     rd;
  logic [7:0]           rd_data;
  sfd_pkg::store_stat_t stat;
  sfd_pkg::result_t     res;
  logic                 res_ready;
  logic                 busy;
  logic                 in_accept;

  sfd_pkg::idx_t        out_index;
  sfd_pkg::val_t        out_value;
  sfd_pkg::adj_t        out_adj;
  logic                 out_fs;
  logic                 out_last;
  logic                 out_valid;

  assign s_tready  = !busy && !stat.start;
  assign in_accept = s_tvalid && s_tready;

  sfd_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .wr_accept (in_accept),
    .wr_byte   (s_tdata),
    .rd        (rd),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  sfd_unpack u_unpack (
    .clk       (clk),
    .rst       (rst),
    .start     (stat.start),
    .rd_data   (rd_data),
    .rd        (rd),
    .res       (res),
    .res_ready (res_ready),
    .busy      (busy)
  );

  assign res_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_index <= res.index;
      out_value <= res.value;
      out_adj   <= sfd_pkg::adjust(res.value);
      out_fs    <= res.fail_safe;
      out_last  <= res.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_adj, out_value, out_index};
  assign m_tuser  = out_fs;
  assign m_tlast  = out_last;

  `SFD_ASSERT_IMP(a_last_index, m_tvalid && m_tlast, m_tdata[4:0] == sfd_pkg::LAST_IDX, "last result carries wrong channel index")
  `SFD_ASSERT_IMP(a_busy_full_frame, busy || stat.start, stat.pos == sfd_pkg::FRAME_LEN, "decode running without a full frame")
  `SFD_ASSERT_NXT(a_start_decodes, stat.start, busy, "frame completion did not start a decode")

endmodule
